// File: hdl/stq_pkg.sv
// ----------------------------------------------------------------------------
// stq_pkg
// Shared types and constants for the sorted timer queue.
// ----------------------------------------------------------------------------
package stq_pkg;

    localparam int TIMER_SLOTS = 32;
    localparam int SLOT_W      = $clog2(TIMER_SLOTS);
    localparam int CNT_W       = $clog2(TIMER_SLOTS + 1);

    localparam logic [1:0]  FLAGS_FREE  = 2'd0;
    localparam logic [1:0]  FLAGS_ALLOC = 2'd1;
    localparam logic [1:0]  FLAGS_USING = 2'd2;
    localparam logic [31:0] NO_EXPIRY   = 32'hffff_ffff;

    localparam logic KIND_ALLOC  = 1'b0;
    localparam logic KIND_EXPIRY = 1'b1;

    typedef enum logic [2:0] {
        OP_ALLOC   = 3'd0,
        OP_FREE    = 3'd1,
        OP_INIT    = 3'd2,
        OP_SETTIME = 3'd3,
        OP_TICK    = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ALLOC,
        ST_UNLINK,
        ST_INS_ADDR,
        ST_INS_CMP,
        ST_FETCH,
        ST_CHECK
    } state_t;

endpackage

// File: hdl/sorted_timer_queue_core.sv
// ----------------------------------------------------------------------------
// sorted_timer_queue_core
// Timer slot pool with an armed list kept sorted by absolute expiry tick.
// ----------------------------------------------------------------------------
// Usage: commands arrive on the in channel (in_valid/in_ready); results leave
// on the out channel (out_valid/out_ready) through one output register.
// One command is worked on at a time; in_ready is high only while idle.
// Alloc scans the slot flags one slot per cycle and answers with the lowest
// free slot, or with alloc_ok low for a full pool. Init writes the slot's
// destination and data and gives no result. Free or set timeout of an
// armed slot walks the sorted list one entry per cycle to unlink it; set
// timeout then walks it to insert, each entry taking an address state and a
// compare state through the expiry memory read port; then a fetch state and
// a check state refresh the head expiry. A tick with nothing due only
// advances the tick count; a tick that fires gives one transfer per expired
// slot, the final one marked last_of_run.
// Reset clears the tick count, the list and all slot flags at once; no
// clearing pass is needed. When the receiver stalls, the block holds the
// result in the output register and waits before emitting the next one.
// ----------------------------------------------------------------------------
module sorted_timer_queue_core
    import stq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [2:0]        operation,
    input  logic [4:0]        slot_id,
    input  logic [7:0]        dest_id,
    input  logic [31:0]       data_word,
    input  logic [31:0]       timeout_ticks,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              kind,
    output logic              alloc_ok,
    output logic [4:0]        got_slot,
    output logic [7:0]        out_dest,
    output logic [31:0]       out_data,
    output logic              last_of_run
);

    state_t state_reg, state_next;

    logic [31:0]       tick_reg, tick_next;
    logic [31:0]       next_exp_reg, next_exp_next;
    logic [CNT_W-1:0]  armed_reg, armed_next;
    logic [1:0]        flags_reg [TIMER_SLOTS];
    logic [1:0]        flags_next [TIMER_SLOTS];
    logic [SLOT_W-1:0] order_reg [TIMER_SLOTS];
    logic [SLOT_W-1:0] order_next [TIMER_SLOTS];

    logic [CNT_W-1:0]  idx_reg, idx_next;
    op_t               op_reg, op_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [31:0]       exp_reg, exp_next;

    logic              pend_valid_reg, pend_valid_next;
    logic [SLOT_W-1:0] pend_slot_reg, pend_slot_next;
    logic [7:0]        pend_dest_reg, pend_dest_next;
    logic [31:0]       pend_data_reg, pend_data_next;

    logic              out_valid_reg, out_valid_next;
    logic              kind_reg, kind_next;
    logic              ok_reg, ok_next;
    logic [4:0]        got_reg, got_next;
    logic [7:0]        dest_reg, dest_next;
    logic [31:0]       data_reg, data_next;
    logic              last_reg, last_next;

    logic [31:0]       exp_mem  [TIMER_SLOTS];
    logic [7:0]        dest_mem [TIMER_SLOTS];
    logic [31:0]       data_mem [TIMER_SLOTS];
    logic [31:0]       rd_exp_reg;
    logic [7:0]        rd_dest_reg;
    logic [31:0]       rd_data_reg;
    logic [SLOT_W-1:0] rd_addr;

    logic              accept;
    logic              in_range;
    op_t               in_op;
    logic              out_free;
    logic              fire;
    logic              walk_end;
    logic [31:0]       tick_inc;
    logic [31:0]       set_exp;
    logic              alloc_hit;
    logic              alloc_end;
    logic              unlink_hit;
    logic              ins_place;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign in_op    = op_t'(operation);
    assign in_range = (32'(slot_id) < 32'(TIMER_SLOTS));
    assign out_free = !out_valid_reg || out_ready;
    assign tick_inc = tick_reg + 32'd1;
    assign set_exp  = tick_reg + timeout_ticks;

    assign rd_addr = (state_reg == ST_INS_ADDR || state_reg == ST_INS_CMP)
                   ? order_reg[idx_reg[SLOT_W-1:0]] : order_reg[0];

    assign walk_end   = (idx_reg == armed_reg);
    assign fire       = (op_reg == OP_TICK) && (armed_reg != '0)
                      && (rd_exp_reg <= tick_reg);
    assign alloc_end  = (idx_reg == CNT_W'(TIMER_SLOTS));
    assign alloc_hit  = !alloc_end && (flags_reg[idx_reg[SLOT_W-1:0]] == FLAGS_FREE);
    assign unlink_hit = !walk_end && (order_reg[idx_reg[SLOT_W-1:0]] == slot_reg);
    assign ins_place  = (rd_exp_reg >= exp_reg);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (in_op)
                        OP_ALLOC: state_next = ST_ALLOC;
                        OP_TICK:
                        begin
                            if (next_exp_reg <= tick_inc)
                                state_next = ST_FETCH;
                        end
                        OP_FREE:
                        begin
                            if (in_range && flags_reg[slot_id] == FLAGS_USING)
                                state_next = ST_UNLINK;
                        end
                        OP_SETTIME:
                        begin
                            if (in_range)
                                state_next = (flags_reg[slot_id] == FLAGS_USING)
                                           ? ST_UNLINK : ST_INS_ADDR;
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_ALLOC:
            begin
                if ((alloc_hit || alloc_end) && out_free)
                    state_next = ST_IDLE;
            end
            ST_UNLINK:
            begin
                if (unlink_hit || walk_end)
                    state_next = (op_reg == OP_SETTIME) ? ST_INS_ADDR : ST_FETCH;
            end
            ST_INS_ADDR:
            begin
                state_next = walk_end ? ST_FETCH : ST_INS_CMP;
            end
            ST_INS_CMP:
            begin
                state_next = ins_place ? ST_FETCH : ST_INS_ADDR;
            end
            ST_FETCH:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (!pend_valid_reg || out_free)
                    state_next = fire ? ST_FETCH : ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        tick_next       = tick_reg;
        next_exp_next   = next_exp_reg;
        armed_next      = armed_reg;
        flags_next      = flags_reg;
        order_next      = order_reg;
        idx_next        = idx_reg;
        op_next         = op_reg;
        slot_next       = slot_reg;
        exp_next        = exp_reg;
        pend_valid_next = pend_valid_reg;
        pend_slot_next  = pend_slot_reg;
        pend_dest_next  = pend_dest_reg;
        pend_data_next  = pend_data_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        kind_next       = kind_reg;
        ok_next         = ok_reg;
        got_next        = got_reg;
        dest_next       = dest_reg;
        data_next       = data_reg;
        last_next       = last_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next   = in_op;
                    slot_next = slot_id;
                    exp_next  = set_exp;
                    idx_next  = '0;
                    if (in_op == OP_TICK)
                        tick_next = tick_inc;
                    if (in_op == OP_FREE && in_range)
                        flags_next[slot_id] = FLAGS_FREE;
                    if (in_op == OP_SETTIME && in_range)
                        flags_next[slot_id] = FLAGS_USING;
                end
            end
            ST_ALLOC:
            begin
                if ((alloc_hit || alloc_end) && out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = KIND_ALLOC;
                    ok_next        = alloc_hit;
                    got_next       = alloc_hit ? idx_reg[SLOT_W-1:0] : '0;
                    dest_next      = '0;
                    data_next      = '0;
                    last_next      = 1'b1;
                    if (alloc_hit)
                        flags_next[idx_reg[SLOT_W-1:0]] = FLAGS_ALLOC;
                end
                else if (!alloc_hit && !alloc_end)
                begin
                    idx_next = idx_reg + CNT_W'(1);
                end
            end
            ST_UNLINK:
            begin
                if (unlink_hit)
                begin
                    // close the gap left by the removed entry
                    for (int j = 0; j < TIMER_SLOTS - 1; j++)
                    begin
                        if (j >= int'(idx_reg))
                            order_next[j] = order_reg[j+1];
                    end
                    armed_next = armed_reg - CNT_W'(1);
                    idx_next   = '0;
                end
                else if (walk_end)
                begin
                    idx_next = '0;
                end
                else
                begin
                    idx_next = idx_reg + CNT_W'(1);
                end
            end
            ST_INS_ADDR:
            begin
                if (walk_end)
                begin
                    order_next[idx_reg[SLOT_W-1:0]] = slot_reg;
                    armed_next = armed_reg + CNT_W'(1);
                end
            end
            ST_INS_CMP:
            begin
                if (ins_place)
                begin
                    // open a gap at the insertion point
                    for (int j = 1; j < TIMER_SLOTS; j++)
                    begin
                        if (j > int'(idx_reg))
                            order_next[j] = order_reg[j-1];
                    end
                    order_next[idx_reg[SLOT_W-1:0]] = slot_reg;
                    armed_next = armed_reg + CNT_W'(1);
                end
                else
                begin
                    idx_next = idx_reg + CNT_W'(1);
                end
            end
            ST_FETCH:
            begin
            end
            ST_CHECK:
            begin
                if (!pend_valid_reg || out_free)
                begin
                    if (pend_valid_reg)
                    begin
                        out_valid_next = 1'b1;
                        kind_next      = KIND_EXPIRY;
                        ok_next        = 1'b0;
                        got_next       = pend_slot_reg;
                        dest_next      = pend_dest_reg;
                        data_next      = pend_data_reg;
                        last_next      = !fire;
                    end
                    if (fire)
                    begin
                        // hold the expired head until the next one is known
                        pend_valid_next = 1'b1;
                        pend_slot_next  = order_reg[0];
                        pend_dest_next  = rd_dest_reg;
                        pend_data_next  = rd_data_reg;
                        flags_next[order_reg[0]] = FLAGS_ALLOC;
                        for (int j = 0; j < TIMER_SLOTS - 1; j++)
                            order_next[j] = order_reg[j+1];
                        armed_next = armed_reg - CNT_W'(1);
                    end
                    else
                    begin
                        pend_valid_next = 1'b0;
                        next_exp_next   = (armed_reg != '0) ? rd_exp_reg : NO_EXPIRY;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            tick_reg       <= '0;
            next_exp_reg   <= NO_EXPIRY;
            armed_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < TIMER_SLOTS; i++)
                flags_reg[i] <= FLAGS_FREE;
        end
        else
        begin
            state_reg      <= state_next;
            tick_reg       <= tick_next;
            next_exp_reg   <= next_exp_next;
            armed_reg      <= armed_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            flags_reg      <= flags_next;
        end
    end

    always_ff @(posedge clk)
    begin
        order_reg     <= order_next;
        idx_reg       <= idx_next;
        op_reg        <= op_next;
        slot_reg      <= slot_next;
        exp_reg       <= exp_next;
        pend_slot_reg <= pend_slot_next;
        pend_dest_reg <= pend_dest_next;
        pend_data_reg <= pend_data_next;
        kind_reg      <= kind_next;
        ok_reg        <= ok_next;
        got_reg       <= got_next;
        dest_reg      <= dest_next;
        data_reg      <= data_next;
        last_reg      <= last_next;
    end

    // Slot memories: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (accept && in_range && in_op == OP_SETTIME)
            exp_mem[slot_id] <= set_exp;
        if (accept && in_range && in_op == OP_INIT)
        begin
            dest_mem[slot_id] <= dest_id;
            data_mem[slot_id] <= data_word;
        end
        rd_exp_reg  <= exp_mem[rd_addr];
        rd_dest_reg <= dest_mem[rd_addr];
        rd_data_reg <= data_mem[rd_addr];
    end

    assign out_valid   = out_valid_reg;
    assign kind        = kind_reg;
    assign alloc_ok    = ok_reg;
    assign got_slot    = got_reg;
    assign out_dest    = dest_reg;
    assign out_data    = data_reg;
    assign last_of_run = last_reg;

`ifndef SYNTH
    a_armed_bound: assert property (@(posedge clk) disable iff (!rst_n)
        armed_reg <= CNT_W'(TIMER_SLOTS))
        else $error("armed count beyond pool size");

    a_empty_no_expiry: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && armed_reg == '0) |-> (next_exp_reg == NO_EXPIRY))
        else $error("empty list with pending expiry");

    a_alloc_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && kind_reg == KIND_ALLOC) |-> last_reg)
        else $error("alloc reply not marked last");

    a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !pend_valid_reg)
        else $error("expiry left pending at idle");
`endif

endmodule

// File: dv/sorted_timer_queue_core_test.sv
// ----------------------------------------------------------------------------
// sorted_timer_queue_core_test
// Self-checking bench for the sorted timer queue. A scoreboard class keeps
// its own copy of the slot pool and the sorted armed list, predicts every
// alloc reply and expiry event, and compares each output transfer in order.
// Directed commands cover the edges, then weighted random traffic follows.
// ----------------------------------------------------------------------------
module sorted_timer_queue_core_test
    import stq_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic        kind;
        logic        ok;
        logic [4:0]  slot;
        logic [7:0]  dest;
        logic [31:0] data;
        logic        last;
    } timer_event_t;

    class timer_scoreboard;
        logic [31:0]  count;
        logic [31:0]  head_expiry;
        int           n_armed;
        logic [1:0]   flags [TIMER_SLOTS];
        logic [31:0]  expiry [TIMER_SLOTS];
        logic [7:0]   dest [TIMER_SLOTS];
        logic [31:0]  data [TIMER_SLOTS];
        int           order [TIMER_SLOTS];
        timer_event_t due_events [$];
        int           errors;
        int           checked;
        int           fired;

        function new();
            count = '0;
            head_expiry = NO_EXPIRY;
            n_armed = 0;
            errors = 0;
            checked = 0;
            fired = 0;
            for (int i = 0; i < TIMER_SLOTS; i++)
            begin
                flags[i] = FLAGS_FREE;
                expiry[i] = '0;
                dest[i] = '0;
                data[i] = '0;
                order[i] = 0;
            end
        endfunction

        function void refresh_head();
            head_expiry = (n_armed > 0) ? expiry[order[0]] : NO_EXPIRY;
        endfunction

        function void unlink(int s);
            int j;
            j = 0;
            for (int i = 0; i < n_armed; i++)
            begin
                if (order[i] != s)
                begin
                    order[j] = order[i];
                    j++;
                end
            end
            n_armed = j;
            refresh_head();
        endfunction

        function void note_command(logic [2:0] op, logic [4:0] s, logic [7:0] d,
                                   logic [31:0] w, logic [31:0] tmo);
            timer_event_t ev;
            logic [31:0] at;
            int i;
            int n;
            bit found;
            if (op == OP_ALLOC)
            begin
                found = 0;
                ev = '{KIND_ALLOC, 1'b0, 5'd0, 8'd0, 32'd0, 1'b1};
                for (int k = 0; k < TIMER_SLOTS; k++)
                begin
                    if (!found && flags[k] == FLAGS_FREE)
                    begin
                        flags[k] = FLAGS_ALLOC;
                        ev.ok = 1'b1;
                        ev.slot = k[4:0];
                        found = 1;
                    end
                end
                due_events.push_back(ev);
            end
            else if (op == OP_TICK)
            begin
                count = count + 32'd1;
                if (head_expiry <= count)
                begin
                    n = 0;
                    while (n < n_armed && expiry[order[n]] <= count)
                    begin
                        flags[order[n]] = FLAGS_ALLOC;
                        ev = '{KIND_EXPIRY, 1'b0, order[n][4:0], dest[order[n]],
                               data[order[n]], 1'b0};
                        due_events.push_back(ev);
                        n++;
                    end
                    if (n > 0)
                        due_events[$].last = 1'b1;
                    fired += n;
                    n_armed -= n;
                    for (int k = 0; k < n_armed; k++)
                        order[k] = order[k + n];
                    refresh_head();
                end
            end
            else if (op == OP_FREE)
            begin
                if (flags[s] == FLAGS_USING)
                    unlink(s);
                flags[s] = FLAGS_FREE;
            end
            else if (op == OP_INIT)
            begin
                dest[s] = d;
                data[s] = w;
            end
            else if (op == OP_SETTIME)
            begin
                at = count + tmo;
                if (flags[s] == FLAGS_USING)
                    unlink(s);
                expiry[s] = at;
                flags[s] = FLAGS_USING;
                i = 0;
                while (i < n_armed && expiry[order[i]] < at)
                    i++;
                for (int k = n_armed; k > i; k--)
                    order[k] = order[k - 1];
                order[i] = s;
                n_armed++;
                refresh_head();
            end
        endfunction

        function void check_result(timer_event_t got);
            timer_event_t want;
            if (due_events.size() == 0)
            begin
                $error("unexpected transfer: kind %0d slot %0d", got.kind, got.slot);
                errors++;
                return;
            end
            want = due_events.pop_front();
            checked++;
            if (got.kind !== want.kind)
            begin
                $error("kind: expected %0d, actual %0d", want.kind, got.kind);
                errors++;
            end
            if (got.ok !== want.ok)
            begin
                $error("alloc_ok: expected %0d, actual %0d", want.ok, got.ok);
                errors++;
            end
            if (got.slot !== want.slot)
            begin
                $error("got_slot: expected %0d, actual %0d", want.slot, got.slot);
                errors++;
            end
            if (got.dest !== want.dest)
            begin
                $error("out_dest: expected %0h, actual %0h", want.dest, got.dest);
                errors++;
            end
            if (got.data !== want.data)
            begin
                $error("out_data: expected %0h, actual %0h", want.data, got.data);
                errors++;
            end
            if (got.last !== want.last)
            begin
                $error("last_of_run: expected %0d, actual %0d", want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [2:0]  operation;
    logic [4:0]  slot_id;
    logic [7:0]  dest_id;
    logic [31:0] data_word;
    logic [31:0] timeout_ticks;
    logic        out_valid;
    logic        out_ready;
    logic        kind;
    logic        alloc_ok;
    logic [4:0]  got_slot;
    logic [7:0]  out_dest;
    logic [31:0] out_data;
    logic        last_of_run;

    timer_scoreboard sb;
    bit              bound [TIMER_SLOTS];
    int              sent;
    int              burst_left;
    int              cycle;

    sorted_timer_queue_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .operation     (operation),
        .slot_id       (slot_id),
        .dest_id       (dest_id),
        .data_word     (data_word),
        .timeout_ticks (timeout_ticks),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .kind          (kind),
        .alloc_ok      (alloc_ok),
        .got_slot      (got_slot),
        .out_dest      (out_dest),
        .out_data      (out_data),
        .last_of_run   (last_of_run)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Present one command and hold it until the transfer. A slot that was
    // never bound gets an init in place of set timeout, so no expiry
    // ever reports unbound contents.
    task automatic issue(logic [2:0] op, logic [4:0] s, logic [7:0] d,
                         logic [31:0] w, logic [31:0] tmo);
        if (op == OP_SETTIME && !bound[s])
            op = OP_INIT;
        if (op == OP_INIT)
            bound[s] = 1;
        in_valid      <= 1'b1;
        operation     <= op;
        slot_id       <= s;
        dest_id       <= d;
        data_word     <= w;
        timeout_ticks <= tmo;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_command(op, s, d, w, tmo);
        sent++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 12);
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15))
                @(posedge clk);
        end
    endtask

    task automatic issue_random();
        int pick;
        logic [31:0] tmo;
        pick = $urandom_range(0, 99);
        tmo = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 12);
        if (pick < 30)
            issue(OP_TICK, 5'($urandom), 8'($urandom), $urandom, $urandom);
        else if (pick < 55)
            issue(OP_SETTIME, 5'($urandom), 8'($urandom), $urandom, tmo);
        else if (pick < 70)
            issue(OP_ALLOC, 5'($urandom), 8'($urandom), $urandom, $urandom);
        else if (pick < 80)
            issue(OP_FREE, 5'($urandom), 8'($urandom), $urandom, $urandom);
        else if (pick < 95)
            issue(OP_INIT, 5'($urandom), 8'($urandom), $urandom, $urandom);
        else
            issue(3'($urandom_range(5, 7)), 5'($urandom), 8'($urandom), $urandom,
                  $urandom);
    endtask

    // Receiver: a rotating pattern of ready behaviours, plus one long hold-off
    // so that the output register fills and the input side stalls.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result('{kind, alloc_ok, got_slot, out_dest, out_data, last_of_run});
        cycle <= cycle + 1;
        if (cycle >= 1500 && cycle < 1900)
            out_ready <= 1'b0;
        else
            case ((cycle / 64) % 3)
                0: out_ready <= 1'b1;
                1: out_ready <= ($urandom_range(0, 1) == 0);
                default: out_ready <= ($urandom_range(0, 4) != 0);
            endcase
    end

    initial
    begin
        #2ms;
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        sb = new();
        sent = 0;
        burst_left = 0;
        cycle = 0;
        for (int i = 0; i < TIMER_SLOTS; i++)
            bound[i] = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_ready = 1'b0;
        operation = '0;
        slot_id = '0;
        dest_id = '0;
        data_word = '0;
        timeout_ticks = '0;
        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed edges
        issue(OP_ALLOC, 5'd0, 8'd0, 32'd0, 32'd0);
        issue(OP_ALLOC, 5'd31, 8'hff, '1, '1);
        issue(OP_INIT, 5'd0, 8'hff, 32'hffff_ffff, 32'd0);
        issue(OP_INIT, 5'd31, 8'h00, 32'h0000_0000, '1);
        issue(OP_INIT, 5'd5, 8'ha5, 32'h5a5a_a5a5, 32'd0);
        issue(OP_TICK, 5'd0, 8'd0, 32'd0, 32'd0);         // nothing due
        issue(OP_SETTIME, 5'd0, 8'd0, 32'd0, 32'd0);      // fires next tick
        issue(OP_SETTIME, 5'd31, 8'd0, 32'd0, 32'hffff_ffff); // wraps below count
        issue(OP_SETTIME, 5'd5, 8'd0, 32'd0, 32'd0);      // tie with slot 0
        issue(OP_TICK, 5'd0, 8'd0, 32'd0, 32'd0);
        issue(OP_SETTIME, 5'd5, 8'd0, 32'd0, 32'd3);
        issue(OP_SETTIME, 5'd5, 8'd0, 32'd0, 32'd1);      // re-arm
        issue(OP_SETTIME, 5'd0, 8'd0, 32'd0, 32'd2);
        issue(OP_FREE, 5'd0, 8'd0, 32'd0, 32'd0);         // free while armed
        issue(OP_SETTIME, 5'd31, 8'd0, 32'd0, 32'h8000_0000);
        issue(3'd7, 5'd31, 8'hff, '1, '1);
        issue(3'd5, 5'd0, 8'd0, 32'd0, 32'd0);
        issue(OP_TICK, 5'd0, 8'd0, 32'd0, 32'd0);
        issue(OP_TICK, 5'd0, 8'd0, 32'd0, 32'd0);
        issue(OP_FREE, 5'd31, 8'd0, 32'd0, 32'd0);
        // drain the pool to hit the full case
        repeat (33)
            issue(OP_ALLOC, 5'($urandom), 8'($urandom), $urandom, $urandom);

        for (int k = 0; k < 120; k++)
            issue_random();

        in_valid <= 1'b0;
        while (sb.due_events.size() > 0)
            @(posedge clk);
        repeat (300)
            @(posedge clk);
        if (sb.due_events.size() > 0)
        begin
            $error("%0d expected results never arrived", sb.due_events.size());
            sb.errors++;
        end

        $display("Sent %0d commands, checked %0d results, %0d of them timer expiries.",
                 sent, sb.checked, sb.fired);
        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// File: files.f
hdl/stq_pkg.sv
hdl/sorted_timer_queue_core.sv
dv/sorted_timer_queue_core_test.sv
